// ===== rtl/core/imu_raw_to_units_converter_top_assert.svh =====
// Assertion macros used by the converter's top-level RTL file.
`ifndef IMU_RAW_TO_UNITS_CONVERTER_TOP_ASSERT_SVH
`define IMU_RAW_TO_UNITS_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define IMU_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu converter assertion failed");

`define IMU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu converter assertion failed");

`else

`define IMU_ASSERT_IMPLIES(label, ante, cons)

`define IMU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/imu_cvt_pkg.sv =====
// Package with the converter's constants, types and the arcsine table.
package imu_cvt_pkg;

  localparam int FRACTION_BITS      = 8;
  localparam int ASIN_TABLE_ENTRIES = 256;

  localparam int RAW_W     = 16;
  localparam int OPC_W     = 2;
  localparam int OUT_W     = 21;
  localparam int DIFF_W    = RAW_W + 1;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_ACCEL   = 2'd0,
    OP_GYRO    = 2'd1,
    OP_TEMP    = 2'd2,
    OP_INVALID = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_OFFSET = 2'd0,
    REG_GYRO_OFFSET  = 2'd1
  } cfg_idx_t;

  localparam int RATIO_ONE  = 16384;
  localparam int TILT_SHIFT = 14;
  localparam int TILT_HALF  = RATIO_ONE / 2;

  localparam longint TAB_TOP = longint'(90) << FRACTION_BITS;
  localparam int     TAB_W   = $clog2(TAB_TOP + 1);
  localparam int     IDX_W   = $clog2(ASIN_TABLE_ENTRIES + 1);
  localparam int     M_W     = TILT_SHIFT + 1;
  localparam int     P_W     = TILT_SHIFT + IDX_W;

  localparam int     DIV_SHIFT  = 32;
  localparam longint GYRO_DIV   = 82;
  localparam longint GYRO_NUM   = longint'(5) << FRACTION_BITS;
  localparam longint GYRO_Q     = GYRO_NUM / GYRO_DIV;
  localparam longint GYRO_R     = GYRO_NUM % GYRO_DIV;
  localparam longint GYRO_HALF  = GYRO_DIV / 2;
  localparam longint GYRO_RECIP = ((longint'(1) << DIV_SHIFT) + GYRO_DIV - 1) / GYRO_DIV;

  localparam longint TEMP_DIV    = 340;
  localparam longint TEMP_NUM    = longint'(1) << FRACTION_BITS;
  localparam longint TEMP_Q      = TEMP_NUM / TEMP_DIV;
  localparam longint TEMP_R      = TEMP_NUM % TEMP_DIV;
  localparam longint TEMP_HALF   = TEMP_DIV / 2;
  localparam longint TEMP_RECIP  = ((longint'(1) << DIV_SHIFT) + TEMP_DIV - 1) / TEMP_DIV;
  localparam int     TEMP_OFFSET = 12325;

  localparam longint GYRO_Y_MAX = longint'(65535) * GYRO_R + GYRO_HALF;
  localparam longint TEMP_Y_MAX = longint'(32767 + TEMP_OFFSET) * TEMP_R + TEMP_HALF;
  localparam longint Y_MAX      = (GYRO_Y_MAX > TEMP_Y_MAX) ? GYRO_Y_MAX : TEMP_Y_MAX;
  localparam int     Y_W        = $clog2(Y_MAX + 1);
  localparam int     MUL_A_W    = (Y_W > TAB_W) ? Y_W : TAB_W;
  localparam int     RECIP_W    = $clog2(GYRO_RECIP + 1);
  localparam int     MUL_B_W    = (RECIP_W > TILT_SHIFT) ? RECIP_W : TILT_SHIFT;
  localparam int     PROD_W     = MUL_A_W + MUL_B_W;

  localparam int GYRO_BASE_W = RAW_W + $clog2(GYRO_Q + 1);
  localparam int BASE_W0     = (GYRO_BASE_W > TAB_W) ? GYRO_BASE_W : TAB_W;
  localparam int BASE_W      = (BASE_W0 > OUT_W) ? BASE_W0 : OUT_W;
  localparam int MAG_W       = BASE_W + 1;

  localparam longint ONE_FIXED   = longint'(1) << FRACTION_BITS;
  localparam longint OUT_MAX_MAG = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN_MAG = longint'(1) << (OUT_W - 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX   = OUT_W'(OUT_MAX_MAG);
  localparam logic signed [OUT_W-1:0] OUT_MIN   = OUT_W'(-OUT_MIN_MAG);
  localparam logic signed [OUT_W-1:0] BAD_VALUE = OUT_W'(-ONE_FIXED);
  localparam logic signed [OUT_W-1:0] TILT_POS_LIM =
    OUT_W'((TAB_TOP > OUT_MAX_MAG) ? OUT_MAX_MAG : TAB_TOP);
  localparam logic signed [OUT_W-1:0] TILT_NEG_LIM =
    OUT_W'((TAB_TOP > OUT_MIN_MAG) ? -OUT_MIN_MAG : -TAB_TOP);

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               is_tilt;
    logic               neg;
    logic               bad;
    logic               clipped;
  } mid_t;

  typedef logic [ASIN_TABLE_ENTRIES:0][TAB_W-1:0] asin_tab_t;

  localparam longint PI_Q30 = 64'sd3373259426;

  // The angle scale 180 << FRACTION_BITS equals 45 << (FRACTION_BITS + 2).
  localparam int     ANGLE_SHIFT       = FRACTION_BITS + 2;
  localparam longint ANGLE_DIV         = 45;
  localparam int     ANGLE_RECIP_SHIFT = 48;
  localparam longint ANGLE_RECIP       =
    ((longint'(1) << ANGLE_RECIP_SHIFT) + ANGLE_DIV - 1) / ANGLE_DIV;

  localparam int     TERM_RECIP_SHIFT = 40;
  localparam longint TERM_ONE         = longint'(1) << TERM_RECIP_SHIFT;
  localparam longint TERM_RECIP_1     = (TERM_ONE + 6 - 1) / 6;
  localparam longint TERM_RECIP_2     = (TERM_ONE + 20 - 1) / 20;
  localparam longint TERM_RECIP_3     = (TERM_ONE + 42 - 1) / 42;
  localparam longint TERM_RECIP_4     = (TERM_ONE + 72 - 1) / 72;
  localparam longint TERM_RECIP_5     = (TERM_ONE + 110 - 1) / 110;
  localparam longint TERM_RECIP_6     = (TERM_ONE + 156 - 1) / 156;
  localparam longint TERM_RECIP_7     = (TERM_ONE + 210 - 1) / 210;

  // Floor of a non-negative value times a rounded-up reciprocal, shifted back down.
  function automatic longint mul_shift(input longint x, input longint m, input int s);
    logic [127:0] p;
    p = 128'(x) * 128'(m);
    p = p >> s;
    return longint'(p[63:0]);
  endfunction

  // Sine in Q30 of an angle given in fixed-point degrees, by a truncated Taylor series.
  // The reciprocals are exact floor divisions over the whole angle range.
  function automatic longint sine_q30(input longint ang);
    longint r;
    longint term;
    longint sum;
    longint recip;
    r    = mul_shift((ang * PI_Q30) >> ANGLE_SHIFT, ANGLE_RECIP, ANGLE_RECIP_SHIFT);
    term = r;
    sum  = r;
    for (int k = 1; k <= 7; k++) begin
      term = (term * r) >> 30;
      term = (term * r) >> 30;
      unique case (k)
        1:       recip = TERM_RECIP_1;
        2:       recip = TERM_RECIP_2;
        3:       recip = TERM_RECIP_3;
        4:       recip = TERM_RECIP_4;
        5:       recip = TERM_RECIP_5;
        6:       recip = TERM_RECIP_6;
        default: recip = TERM_RECIP_7;
      endcase
      term = mul_shift(term, recip, TERM_RECIP_SHIFT);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Each entry is the grid angle whose sine lies nearest to i/N, kept non-decreasing.
  function automatic asin_tab_t build_asin_tab();
    asin_tab_t tab;
    longint    x;
    longint    lo;
    longint    hi;
    longint    mid;
    longint    d0;
    longint    d1;
    longint    prev;
    tab  = '0;
    prev = 0;
    for (int i = 0; i <= ASIN_TABLE_ENTRIES; i++) begin
      x  = (longint'(i) << 30) / ASIN_TABLE_ENTRIES;
      lo = 0;
      hi = TAB_TOP;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (sine_q30(mid) >= x) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      if (lo > 0) begin
        d1 = sine_q30(lo) - x;
        d0 = x - sine_q30(lo - 1);
        if (d1 < 0) begin
          d1 = -d1;
        end
        if (d0 < 0) begin
          d0 = -d0;
        end
        if (d0 < d1) begin
          lo = lo - 1;
        end
      end
      if (i == 0) begin
        lo = 0;
      end
      if (i == ASIN_TABLE_ENTRIES) begin
        lo = TAB_TOP;
      end
      if (i > 0 && lo < prev) begin
        lo = prev;
      end
      tab[i] = TAB_W'(lo);
      prev   = lo;
    end
    return tab;
  endfunction

  localparam asin_tab_t ASIN_TAB = build_asin_tab();

endpackage

// ===== rtl/core/imu_raw_to_units_converter_top.sv =====
// Top level of the raw inertial sample to physical units converter.
//
// Input channel (in_valid/in_ready) carries a signed 16-bit raw sample and a
// two-bit channel code: accelerometer tilt, gyroscope rate, temperature or an
// invalid code. Each transfer produces exactly one result transfer on the
// output channel (out_valid/out_ready): a signed value with the package's
// fraction bits, plus a bad-channel flag and a tilt-clipped flag.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes the
// accelerometer and gyroscope zero offsets; indexes beyond them are ignored.
// Three register stages sit between the channels: input, table lookup and
// divisor split, then multiply and saturation. A result is offered once it
// has passed all three, and one item is taken every cycle while the receiver
// keeps up. When the receiver stalls, the stages fill and in_ready drops once
// all three hold an item; nothing is dropped. Reset empties the stages and
// clears both offsets; the arcsine table is constant logic and needs no
// set-up time.
module imu_raw_to_units_converter_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [imu_cvt_pkg::RAW_W-1:0]  in_raw_sample,
  input  logic [imu_cvt_pkg::OPC_W-1:0]         in_opcode,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [imu_cvt_pkg::OUT_W-1:0]  out_value_fixed,
  output logic                                  out_bad_channel,
  output logic                                  out_tilt_clipped,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [imu_cvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imu_cvt_pkg::RAW_W-1:0]         cfg_data
);
  import imu_cvt_pkg::*;

  `include "imu_raw_to_units_converter_top_assert.svh"

  logic                     in_valid_r;
  logic signed [RAW_W-1:0]  raw_r;
  opcode_t                  opcode_r;
  logic signed [RAW_W-1:0]  accel_offset_r;
  logic signed [RAW_W-1:0]  gyro_offset_r;
  logic                     mid_valid;
  mid_t                     mid;
  logic                     mid_en;
  logic                     out_en;

  assign cfg_ready = 1'b1;
  assign out_en    = !out_valid || out_ready;
  assign mid_en    = !mid_valid || out_en;
  assign in_ready  = !in_valid_r || mid_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_offset_r <= '0;
      gyro_offset_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ACCEL_OFFSET: accel_offset_r <= cfg_data;
        REG_GYRO_OFFSET:  gyro_offset_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      raw_r    <= in_raw_sample;
      opcode_r <= opcode_t'(in_opcode);
    end
  end

  imu_cvt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (mid_en),
    .in_valid     (in_valid_r),
    .raw_sample   (raw_r),
    .opcode       (opcode_r),
    .accel_offset (accel_offset_r),
    .gyro_offset  (gyro_offset_r),
    .mid_valid_r  (mid_valid),
    .mid_r        (mid)
  );

  imu_cvt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (out_en),
    .mid_valid   (mid_valid),
    .mid         (mid),
    .out_valid_r (out_valid),
    .value_r     (out_value_fixed),
    .bad_r       (out_bad_channel),
    .clipped_r   (out_tilt_clipped)
  );

  `IMU_ASSERT_NEXT(a_accept_fills_input, in_valid && in_ready, in_valid_r)
  `IMU_ASSERT_IMPLIES(a_bad_value, out_valid && out_bad_channel, (out_value_fixed == BAD_VALUE) && !out_tilt_clipped)
  `IMU_ASSERT_IMPLIES(a_clip_full_scale, out_valid && out_tilt_clipped, (out_value_fixed == TILT_POS_LIM) || (out_value_fixed == TILT_NEG_LIM))

endmodule

// ===== rtl/core/imu_cvt_front.sv =====
// Front stage: offset removal, arcsine table lookup and constant-divisor split.
module imu_cvt_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [imu_cvt_pkg::RAW_W-1:0]   raw_sample,
  input  imu_cvt_pkg::opcode_t                   opcode,
  input  logic signed [imu_cvt_pkg::RAW_W-1:0]   accel_offset,
  input  logic signed [imu_cvt_pkg::RAW_W-1:0]   gyro_offset,
  output logic                                   mid_valid_r,
  output imu_cvt_pkg::mid_t                      mid_r
);
  import imu_cvt_pkg::*;

  logic signed [DIFF_W-1:0] accel_diff;
  logic signed [DIFF_W-1:0] gyro_diff;
  logic signed [DIFF_W-1:0] temp_sum;
  logic [RAW_W-1:0]         accel_mag;
  logic [RAW_W-1:0]         gyro_mag;
  logic [RAW_W-1:0]         temp_mag;
  logic                     accel_clip;
  logic [M_W-1:0]           ratio_m;
  logic [P_W-1:0]           ratio_p;
  logic [IDX_W-1:0]         tab_idx;
  logic [IDX_W-1:0]         tab_idx_hi;
  logic [TILT_SHIFT-1:0]    tab_frac;
  logic [TAB_W-1:0]         tab_lo;
  logic [TAB_W-1:0]         tab_hi;
  logic [TAB_W-1:0]         tab_delta;
  mid_t                     mid_nxt;

  assign accel_diff = DIFF_W'(raw_sample) - DIFF_W'(accel_offset);
  assign gyro_diff  = DIFF_W'(raw_sample) - DIFF_W'(gyro_offset);
  assign temp_sum   = DIFF_W'(raw_sample) + DIFF_W'(TEMP_OFFSET);

  assign accel_mag = accel_diff[DIFF_W-1] ? RAW_W'(-accel_diff) : accel_diff[RAW_W-1:0];
  assign gyro_mag  = gyro_diff[DIFF_W-1]  ? RAW_W'(-gyro_diff)  : gyro_diff[RAW_W-1:0];
  assign temp_mag  = temp_sum[DIFF_W-1]   ? RAW_W'(-temp_sum)   : temp_sum[RAW_W-1:0];

  assign accel_clip = accel_mag > RAW_W'(RATIO_ONE);
  assign ratio_m    = accel_clip ? M_W'(RATIO_ONE) : accel_mag[M_W-1:0];
  assign ratio_p    = P_W'(ratio_m) * P_W'(ASIN_TABLE_ENTRIES);
  assign tab_idx    = ratio_p[P_W-1:TILT_SHIFT];
  assign tab_frac   = ratio_p[TILT_SHIFT-1:0];
  assign tab_idx_hi = (tab_idx == IDX_W'(ASIN_TABLE_ENTRIES)) ? tab_idx : tab_idx + 1'b1;
  assign tab_lo     = ASIN_TAB[tab_idx];
  assign tab_hi     = ASIN_TAB[tab_idx_hi];
  assign tab_delta  = tab_hi - tab_lo;

  always_comb begin
    mid_nxt = '0;
    unique case (opcode)
      OP_ACCEL: begin
        mid_nxt.base    = BASE_W'(tab_lo);
        mid_nxt.mul_a   = MUL_A_W'(tab_delta);
        mid_nxt.mul_b   = MUL_B_W'(tab_frac);
        mid_nxt.is_tilt = 1'b1;
        mid_nxt.neg     = accel_diff[DIFF_W-1];
        mid_nxt.clipped = accel_clip;
      end
      OP_GYRO: begin
        mid_nxt.base  = BASE_W'(gyro_mag) * BASE_W'(GYRO_Q);
        mid_nxt.mul_a = MUL_A_W'(gyro_mag) * MUL_A_W'(GYRO_R) + MUL_A_W'(GYRO_HALF);
        mid_nxt.mul_b = MUL_B_W'(GYRO_RECIP);
        mid_nxt.neg   = !gyro_diff[DIFF_W-1] && (gyro_diff != '0);
      end
      OP_TEMP: begin
        mid_nxt.base  = BASE_W'(temp_mag) * BASE_W'(TEMP_Q);
        mid_nxt.mul_a = MUL_A_W'(temp_mag) * MUL_A_W'(TEMP_R) + MUL_A_W'(TEMP_HALF);
        mid_nxt.mul_b = MUL_B_W'(TEMP_RECIP);
        mid_nxt.neg   = temp_sum[DIFF_W-1];
      end
      OP_INVALID: begin
        mid_nxt.base = BASE_W'(ONE_FIXED);
        mid_nxt.neg  = 1'b1;
        mid_nxt.bad  = 1'b1;
      end
      default: begin
        mid_nxt.bad = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (en) begin
      mid_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= mid_nxt;
    end
  end

endmodule

// ===== rtl/core/imu_cvt_back.sv =====
// Back stage: shared multiply, rounding, sign and saturation into the result register.
module imu_cvt_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  mid_valid,
  input  imu_cvt_pkg::mid_t                     mid,
  output logic                                  out_valid_r,
  output logic signed [imu_cvt_pkg::OUT_W-1:0]  value_r,
  output logic                                  bad_r,
  output logic                                  clipped_r
);
  import imu_cvt_pkg::*;

  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        tilt_frac;
  logic [PROD_W-1:0]        div_frac;
  logic [BASE_W-1:0]        frac;
  logic [MAG_W-1:0]         mag;
  logic signed [OUT_W-1:0]  value_nxt;

  assign prod      = PROD_W'(mid.mul_a) * PROD_W'(mid.mul_b);
  assign tilt_frac = (prod + PROD_W'(TILT_HALF)) >> TILT_SHIFT;
  assign div_frac  = prod >> DIV_SHIFT;
  assign frac      = mid.is_tilt ? BASE_W'(tilt_frac) : BASE_W'(div_frac);
  assign mag       = MAG_W'(mid.base) + MAG_W'(frac);

  always_comb begin
    priority if (mid.neg && (mag > MAG_W'(OUT_MIN_MAG))) begin
      value_nxt = OUT_MIN;
    end else if (mid.neg) begin
      value_nxt = OUT_W'(MAG_W'(0) - mag);
    end else if (mag > MAG_W'(OUT_MAX_MAG)) begin
      value_nxt = OUT_MAX;
    end else begin
      value_nxt = OUT_W'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r   <= value_nxt;
      bad_r     <= mid.bad;
      clipped_r <= mid.clipped;
    end
  end

endmodule

// ===== tb/imu_raw_to_units_converter_top_tb.sv =====
// Self-checking testbench for the raw inertial sample converter: directed table, then random phases.
`timescale 1ns / 100ps

module imu_raw_to_units_converter_top_tb;
  import imu_cvt_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 5;
  localparam int          PHASES       = 12;
  localparam int          PHASE_ITEMS  = 85;
  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          MAX_REPORTS  = 10;

  localparam longint PI_IN_Q30     = 64'sd3373259426;
  localparam longint FULL_SCALE    = 16384;
  localparam longint RIGHT_ANGLE   = longint'(90) << FRACTION_BITS;
  localparam longint GYRO_SCALE    = 5;
  localparam longint GYRO_DEN      = 82;
  localparam longint TEMP_BIAS     = 12325;
  localparam longint TEMP_DEN      = 340;
  localparam longint VALUE_HI      = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint VALUE_LO      = -(longint'(1) << (OUT_W - 1));
  localparam longint GRID_STEP     = FULL_SCALE / ASIN_TABLE_ENTRIES;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    bad;
    logic                    clipped;
  } unit_result_t;

  typedef struct packed {
    bit           typed;
    unit_result_t result;
  } sample_note_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw;
    opcode_t                 op;
    bit                      typed;
    logic signed [OUT_W-1:0] value;
    logic                    bad;
    logic                    clipped;
  } directed_row_t;

  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_ready;
  logic signed [RAW_W-1:0] in_raw_sample    = '0;
  opcode_t                 in_opcode        = OP_ACCEL;
  logic                    out_valid;
  logic                    out_ready        = 1'b0;
  logic signed [OUT_W-1:0] out_value_fixed;
  logic                    out_bad_channel;
  logic                    out_tilt_clipped;
  logic                    cfg_valid        = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index        = REG_ACCEL_OFFSET;
  logic [RAW_W-1:0]        cfg_data         = '0;

  logic signed [RAW_W-1:0] accel_offset;
  logic signed [RAW_W-1:0] gyro_offset;
  longint                  asin_deg [0:ASIN_TABLE_ENTRIES];
  sample_note_t            pending_notes [$];
  unit_result_t            expected_units [$];
  int unsigned             fault_count = 0;
  int unsigned             cycle_count = 0;

  directed_row_t dir_rows [24] = '{
    '{16'sd0,      OP_ACCEL,   1'b1, 21'sd0,      1'b0, 1'b0},
    '{16'sd16384,  OP_ACCEL,   1'b1, 21'sd23040,  1'b0, 1'b0},
    '{-16'sd16384, OP_ACCEL,   1'b1, -21'sd23040, 1'b0, 1'b0},
    '{16'sd16385,  OP_ACCEL,   1'b1, 21'sd23040,  1'b0, 1'b1},
    '{-16'sd16385, OP_ACCEL,   1'b1, -21'sd23040, 1'b0, 1'b1},
    '{16'sh7FFF,   OP_ACCEL,   1'b1, 21'sd23040,  1'b0, 1'b1},
    '{16'sh8000,   OP_ACCEL,   1'b1, -21'sd23040, 1'b0, 1'b1},
    '{16'sd1,      OP_ACCEL,   1'b0, 21'sd0,      1'b0, 1'b0},
    '{-16'sd1,     OP_ACCEL,   1'b0, 21'sd0,      1'b0, 1'b0},
    '{16'sd64,     OP_ACCEL,   1'b0, 21'sd0,      1'b0, 1'b0},
    '{16'sd8192,   OP_ACCEL,   1'b0, 21'sd0,      1'b0, 1'b0},
    '{16'sd16383,  OP_ACCEL,   1'b0, 21'sd0,      1'b0, 1'b0},
    '{16'sd0,      OP_GYRO,    1'b1, 21'sd0,      1'b0, 1'b0},
    '{16'sh7FFF,   OP_GYRO,    1'b1, -21'sd511485, 1'b0, 1'b0},
    '{16'sh8000,   OP_GYRO,    1'b1, 21'sd511500, 1'b0, 1'b0},
    '{16'sd1,      OP_GYRO,    1'b0, 21'sd0,      1'b0, 1'b0},
    '{-16'sd1,     OP_GYRO,    1'b0, 21'sd0,      1'b0, 1'b0},
    '{-16'sd12325, OP_TEMP,    1'b1, 21'sd0,      1'b0, 1'b0},
    '{16'sh7FFF,   OP_TEMP,    1'b0, 21'sd0,      1'b0, 1'b0},
    '{16'sh8000,   OP_TEMP,    1'b0, 21'sd0,      1'b0, 1'b0},
    '{16'sd0,      OP_TEMP,    1'b0, 21'sd0,      1'b0, 1'b0},
    '{16'sd0,      OP_INVALID, 1'b1, -21'sd256,   1'b1, 1'b0},
    '{16'sh8000,   OP_INVALID, 1'b1, -21'sd256,   1'b1, 1'b0},
    '{16'sh7FFF,   OP_INVALID, 1'b1, -21'sd256,   1'b1, 1'b0}
  };

  imu_raw_to_units_converter_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_sample    (in_raw_sample),
    .in_opcode        (in_opcode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value_fixed  (out_value_fixed),
    .out_bad_channel  (out_bad_channel),
    .out_tilt_clipped (out_tilt_clipped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint taylor_sin_q30(input longint angle);
    longint rad;
    longint term;
    longint acc;
    rad  = (angle * PI_IN_Q30) / (longint'(180) << FRACTION_BITS);
    term = rad;
    acc  = rad;
    for (int k = 1; k <= 7; k++) begin
      term = (term * rad) >> 30;
      term = (term * rad) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  function automatic void fill_asin_deg();
    longint target;
    longint lo;
    longint hi;
    longint mid;
    longint above;
    longint below;
    for (int i = 0; i <= ASIN_TABLE_ENTRIES; i++) begin
      target = (longint'(i) << 30) / ASIN_TABLE_ENTRIES;
      lo     = 0;
      hi     = RIGHT_ANGLE;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (taylor_sin_q30(mid) >= target) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      if (lo > 0) begin
        above = taylor_sin_q30(lo) - target;
        below = target - taylor_sin_q30(lo - 1);
        if (above < 0) begin
          above = -above;
        end
        if (below < 0) begin
          below = -below;
        end
        if (below < above) begin
          lo = lo - 1;
        end
      end
      if (i == 0) begin
        lo = 0;
      end
      if (i == ASIN_TABLE_ENTRIES) begin
        lo = RIGHT_ANGLE;
      end
      if (i > 0 && lo < asin_deg[i-1]) begin
        lo = asin_deg[i-1];
      end
      asin_deg[i] = lo;
    end
  endfunction

  function automatic unit_result_t convert_sample(input logic signed [RAW_W-1:0] raw,
                                                  input opcode_t op);
    unit_result_t res;
    longint       diff;
    longint       mag;
    longint       scaled;
    longint       idx;
    longint       frac;
    longint       quot;
    longint       v;
    res.bad     = 1'b0;
    res.clipped = 1'b0;
    v           = 0;
    case (op)
      OP_ACCEL: begin
        diff        = longint'(raw) - longint'(accel_offset);
        mag         = (diff < 0) ? -diff : diff;
        res.clipped = (mag > FULL_SCALE);
        if (mag > FULL_SCALE) begin
          mag = FULL_SCALE;
        end
        scaled = mag * ASIN_TABLE_ENTRIES;
        idx    = scaled / FULL_SCALE;
        frac   = scaled % FULL_SCALE;
        if (idx >= ASIN_TABLE_ENTRIES) begin
          v = asin_deg[ASIN_TABLE_ENTRIES];
        end else begin
          v = asin_deg[idx] +
              ((asin_deg[idx+1] - asin_deg[idx]) * frac + FULL_SCALE / 2) / FULL_SCALE;
        end
        if (diff < 0) begin
          v = -v;
        end
      end
      OP_GYRO: begin
        diff = longint'(raw) - longint'(gyro_offset);
        mag  = (diff < 0) ? -diff : diff;
        quot = ((mag * GYRO_SCALE << FRACTION_BITS) + GYRO_DEN / 2) / GYRO_DEN;
        v    = (diff < 0) ? quot : -quot;
      end
      OP_TEMP: begin
        diff = longint'(raw) + TEMP_BIAS;
        mag  = (diff < 0) ? -diff : diff;
        quot = ((mag << FRACTION_BITS) + TEMP_DEN / 2) / TEMP_DEN;
        v    = (diff < 0) ? -quot : quot;
      end
      default: begin
        res.bad = 1'b1;
        v       = -(longint'(1) << FRACTION_BITS);
      end
    endcase
    if (v > VALUE_HI) begin
      v = VALUE_HI;
    end
    if (v < VALUE_LO) begin
      v = VALUE_LO;
    end
    res.value = OUT_W'(v);
    return res;
  endfunction

  // Accelerometer samples are mostly placed within one full scale of the offset.
  task automatic pick_sample(output logic signed [RAW_W-1:0] raw, output opcode_t op);
    int unsigned mix;
    longint      target;
    mix = $urandom_range(0, 9);
    op  = (mix < 4) ? OP_ACCEL : (mix < 7) ? OP_GYRO : (mix < 9) ? OP_TEMP : OP_INVALID;
    raw = RAW_W'($urandom);
    if (op == OP_ACCEL) begin
      case ($urandom_range(0, 3))
        1, 2: begin
          target = longint'(accel_offset) + longint'($urandom_range(0, 2 * FULL_SCALE))
                   - FULL_SCALE;
        end
        3: begin
          target = longint'($urandom_range(0, ASIN_TABLE_ENTRIES + 1)) * GRID_STEP
                   + longint'($urandom_range(0, 2)) - 1;
          target = ($urandom_range(0, 1) == 1) ? accel_offset + target : accel_offset - target;
        end
        default: begin
          target = longint'(raw);
        end
      endcase
      if (target >= -32768 && target <= 32767) begin
        raw = RAW_W'(target);
      end
    end else if ($urandom_range(0, 7) == 0) begin
      raw = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
    end
  endtask

  task automatic send_sample(input logic signed [RAW_W-1:0] raw, input opcode_t op,
                             input bit typed, input unit_result_t typed_result);
    pending_notes.push_back('{typed, typed_result});
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    in_opcode     <= op;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    while (expected_units.size() != 0 || pending_notes.size() != 0) @(negedge clk);
  endtask

  initial begin : receiver_pattern
    int unsigned pick;
    int unsigned span;
    @(negedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        out_ready <= 1'b1;
        span = $urandom_range(20, 60);
      end else if (pick < 6) begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 4);
      end else begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 6);
      end
      repeat (span) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    sample_note_t note;
    unit_result_t want;
    if (!rst_n) begin
      accel_offset = '0;
      gyro_offset  = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_OFFSET: accel_offset = cfg_data;
          REG_GYRO_OFFSET:  gyro_offset  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        note = (pending_notes.size() != 0) ? pending_notes.pop_front() : '0;
        if (note.typed) begin
          expected_units.push_back(note.result);
        end else begin
          expected_units.push_back(convert_sample(in_raw_sample, in_opcode));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("Unexpected result transfer: value %0d bad %b clipped %b",
                     out_value_fixed, out_bad_channel, out_tilt_clipped);
          end
        end else begin
          want = expected_units.pop_front();
          if (out_value_fixed !== want.value || out_bad_channel !== want.bad ||
              out_tilt_clipped !== want.clipped) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("Mismatch: expected value %0d bad %b clipped %b, got %0d %b %b",
                       $signed(want.value), want.bad, want.clipped,
                       out_value_fixed, out_bad_channel, out_tilt_clipped);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [RAW_W-1:0] raw;
    opcode_t                 op;
    logic [RAW_W-1:0]        accel_setting;
    logic [RAW_W-1:0]        gyro_setting;
    int unsigned             left;
    int unsigned             burst;
    int unsigned             gap;
    fill_asin_deg();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[r]) begin
      send_sample(dir_rows[r].raw, dir_rows[r].op, dir_rows[r].typed,
                  '{dir_rows[r].value, dir_rows[r].bad, dir_rows[r].clipped});
    end
    in_valid <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_until_drained();
      case (ph)
        0: begin
          accel_setting = 16'h8000;
          gyro_setting  = 16'h7FFF;
        end
        1: begin
          accel_setting = 16'h7FFF;
          gyro_setting  = 16'h8000;
        end
        2: begin
          accel_setting = '0;
          gyro_setting  = '0;
        end
        default: begin
          accel_setting = ($urandom_range(0, 1) == 1) ? RAW_W'($urandom)
                          : RAW_W'($urandom_range(0, 4000)) - 16'd2000;
          gyro_setting  = RAW_W'($urandom);
        end
      endcase
      write_reg(REG_ACCEL_OFFSET, accel_setting);
      write_reg(REG_GYRO_OFFSET, gyro_setting);
      if (ph == 2 || $urandom_range(0, 3) == 0) begin
        write_reg(REG_SPARE_A, RAW_W'($urandom));
        write_reg(REG_SPARE_B, RAW_W'($urandom));
      end
      cfg_valid <= 1'b0;
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) begin
          burst = left;
        end
        repeat (burst) begin
          pick_sample(raw, op);
          send_sample(raw, op, 1'b0, '0);
        end
        left -= burst;
        gap = $urandom_range(0, 7);
        if (gap != 0 || left == 0) begin
          in_valid <= 1'b0;
        end
        if (left != 0) begin
          repeat (gap) @(negedge clk);
        end
      end
    end
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
